### design/itcs_pkg.sv
package itcs_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int RATIO_W        = 24;

    localparam logic [15:0] CROP_DEPTH_RST   = 16'd240;
    localparam logic [15:0] RATIO_OFFSET_RST = 16'd26;

    localparam logic CFG_CROP_DEPTH   = 1'b0;
    localparam logic CFG_RATIO_OFFSET = 1'b1;

    // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for x < 2**22
    localparam logic [20:0] DIV10_MUL   = 21'd1677722;
    localparam int          DIV10_SHIFT = 24;

    typedef struct packed {
        logic [15:0]        intensity;
        logic signed [23:0] height;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [10:0]        split_index;
        logic [10:0]        high_count;
        logic [15:0]        split_intensity;
        logic [23:0]        mean_ratio;
        logic signed [23:0] top_height;
        logic [10:0]        crop_count;
    } t_out;

    typedef struct packed {
        logic [15:0]        intensity;
        logic signed [23:0] height;
    } t_point;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROT_L,
        OP_ROT_R
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_point   pt;
    } t_ring_ctl;

endpackage

### design/itcs_cell.sv
module itcs_cell #(
    parameter int IDX = 0,
    parameter int CW  = 11
) (
    input  logic                i_clk,
    input  itcs_pkg::t_ring_ctl i_ctl,
    input  logic [CW-1:0]       i_count,
    input  itcs_pkg::t_point    i_left,
    input  logic                i_left_gt,
    input  itcs_pkg::t_point    i_right,
    output itcs_pkg::t_point    o_pt,
    output logic                o_gt
);

    itcs_pkg::t_point r_pt;
    logic             w_occ;

    assign w_occ = i_count > CW'(IDX);
    assign o_gt  = w_occ && (r_pt.intensity > i_ctl.pt.intensity);
    assign o_pt  = r_pt;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            itcs_pkg::OP_INSERT: begin
                if (i_left_gt) begin
                    r_pt <= i_left;
                end else if (o_gt || (i_count == CW'(IDX))) begin
                    r_pt <= i_ctl.pt;
                end
            end
            itcs_pkg::OP_ROT_L: begin
                r_pt <= i_right;
            end
            itcs_pkg::OP_ROT_R: begin
                r_pt <= i_left;
            end
            default: begin
            end
        endcase
    end

endmodule

### design/itcs_mul.sv
module itcs_mul #(
    parameter int WA = 66,
    parameter int WB = 27
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WA-1:0]      i_a,
    input  logic [WB-1:0]      i_b,
    output logic               o_done,
    output logic [WA+WB-1:0]   o_prod
);

    localparam int NA  = (WA + 31) / 32;
    localparam int NB  = (WB + 31) / 32;
    localparam int AIW = (NA > 1) ? $clog2(NA) : 1;
    localparam int BIW = (NB > 1) ? $clog2(NB) : 1;
    localparam int ACW = 32 * (NA + NB);
    localparam int SHW = $clog2(ACW) + 1;

    logic [32*NA-1:0] r_a;
    logic [32*NB-1:0] r_b;
    logic [AIW-1:0]   r_ia;
    logic [BIW-1:0]   r_ib;
    logic [ACW-1:0]   r_acc;
    logic             r_busy;
    logic             r_done;
    logic [63:0]      w_pp;
    logic [SHW-1:0]   w_sh;

    assign w_pp   = r_a[32*r_ia +: 32] * r_b[32*r_ib +: 32];
    assign w_sh   = (SHW'(r_ia) + SHW'(r_ib)) << 5;
    assign o_done = r_done;
    assign o_prod = r_acc[WA+WB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= (32*NA)'(i_a);
                r_b    <= (32*NB)'(i_b);
                r_ia   <= '0;
                r_ib   <= '0;
                r_acc  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + (ACW'(w_pp) << w_sh);
                if (r_ia == AIW'(NA - 1)) begin
                    r_ia <= '0;
                    if (r_ib == BIW'(NB - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_ib <= r_ib + 1'b1;
                    end
                end else begin
                    r_ia <= r_ia + 1'b1;
                end
            end
        end
    end

endmodule

### design/itcs_div.sv
module itcs_div #(
    parameter int NW = 46,
    parameter int DW = 39,
    parameter int QW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);

    localparam int RW   = (NW > DW + QW) ? NW : DW + QW;
    localparam int CNTW = $clog2(QW);

    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   r_ds;
    logic [QW-1:0]   r_quo;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic            w_sat;
    logic            w_ge;

    assign w_sat  = (i_den == '0) || (RW'(i_num) >= (RW'(i_den) << QW));
    assign w_ge   = r_rem >= r_ds;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_sat) begin
                    r_quo  <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= RW'(i_num);
                    r_ds   <= RW'(i_den) << (QW - 1);
                    r_quo  <= '0;
                    r_cnt  <= CNTW'(QW - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_ds;
                end
                r_quo <= {r_quo[QW-2:0], w_ge};
                r_ds  <= r_ds >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

### design/intensity_two_class_split_and_top_crop_top.sv
// Points load at one beat per cycle, but only in the load state; o_stall holds them off otherwise.
// After the last beat the split search scores each candidate split through the multiplier and
// steps past the skipped ones, then the ring rotates for the top and crop scans, then the ratio.
// Throughput: one cloud at a time, set by the shared multiplier in the split search.
// The next cloud loads while a result waits in the output register.
// Reset (synchronous, active low) clears control, empties the point count and restores registers.
module intensity_two_class_split_and_top_crop_top #(
    parameter int MAX_POINTS = itcs_pkg::MAX_POINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  itcs_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output itcs_pkg::t_out o_out,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_index,
    input  logic [15:0]    i_cfg_wr_data
);

    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SW   = 16 + CW;
    localparam int SQW  = 2 * SW;
    localparam int NUMW = SQW + CW + 1;
    localparam int DENW = 2 * CW;
    localparam int MBW  = (SW > DENW) ? SW : DENW;
    localparam int MPW  = NUMW + MBW;
    localparam int RNW  = SW + CW + 8;
    localparam int RDW  = CW + SW + 1;
    localparam int QW   = itcs_pkg::RATIO_W;
    localparam int DQW  = CW + 4 + 21;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_Q_CHECK, S_E_SL2, S_E_SH2, S_E_T1, S_E_T2, S_E_DEN,
        S_E_C1, S_E_C2, S_Q_NEXT, S_REW1, S_TOP_FIRST, S_TOP, S_REW2, S_CROP,
        S_R_NUM, S_R_OFF, S_R_DEN, S_DIV, S_FINISH
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic [SW-1:0]    r_total;
    logic [CW-1:0]    r_lo_q;
    logic [CW-1:0]    r_hi_q;
    logic [CW-1:0]    r_q;
    logic [SW-1:0]    r_sl;
    logic [SW-1:0]    r_sh;
    logic [SQW-1:0]   r_p1;
    logic [SQW-1:0]   r_p2;
    logic [NUMW-1:0]  r_cur_num;
    logic [DENW-1:0]  r_cur_den;
    logic [MPW-1:0]   r_c1;
    logic [NUMW-1:0]  r_best_num;
    logic [DENW-1:0]  r_best_den;
    logic             r_have;
    logic [CW-1:0]    r_sp;
    logic [SW-1:0]    r_best_sl;
    logic             r_mul_wait;
    logic             r_div_wait;
    logic signed [23:0] r_top;
    logic [15:0]      r_split_int;
    logic [CW-1:0]    r_crop;
    logic [RNW-1:0]   r_rnum;
    logic [RDW-1:0]   r_rtmp;
    logic [RDW-1:0]   r_rden;
    logic [QW-1:0]    r_ratio;
    itcs_pkg::t_out   r_out;
    logic             r_out_valid;
    logic [15:0]      r_crop_depth;
    logic [15:0]      r_ratio_offset;

    itcs_pkg::t_ring_ctl w_ctl;
    itcs_pkg::t_point    w_pt [MAX_POINTS];
    logic                w_gt [MAX_POINTS];
    itcs_pkg::t_point    w_c0;

    logic             w_accept;
    logic             w_full;
    logic [CW-1:0]    w_hn_q;
    logic [CW-1:0]    w_hn_sp;
    logic [DQW-1:0]   w_lo_prod;
    logic [DQW-1:0]   w_hi_prod;
    logic signed [24:0] w_floor;
    logic signed [24:0] w_h25;

    logic             w_mul_start;
    logic [NUMW-1:0]  w_mul_a;
    logic [MBW-1:0]   w_mul_b;
    logic             w_mul_done;
    logic [MPW-1:0]   w_mul_prod;
    logic             w_div_done;
    logic [QW-1:0]    w_div_quo;

    assign o_stall  = (r_state != S_LOAD);
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CW'(MAX_POINTS));
    assign w_hn_q   = r_count - r_q;
    assign w_hn_sp  = r_count - r_sp;
    assign w_c0     = w_pt[0];
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;

    assign w_lo_prod = DQW'(r_count) * DQW'(itcs_pkg::DIV10_MUL);
    assign w_hi_prod = ((DQW'(r_count) << 3) + DQW'(r_count)) * DQW'(itcs_pkg::DIV10_MUL);

    assign w_floor = $signed({r_top[23], r_top}) - $signed({9'b0, r_crop_depth});
    assign w_h25   = $signed({w_c0.height[23], w_c0.height});

    always_comb begin
        w_ctl.pt = itcs_pkg::t_point'{intensity: i_in.intensity, height: i_in.height};
        w_ctl.op = itcs_pkg::OP_HOLD;
        case (r_state)
            S_LOAD: begin
                if (w_accept && !w_full) begin
                    w_ctl.op = itcs_pkg::OP_INSERT;
                end
            end
            S_Q_NEXT: begin
                w_ctl.op = itcs_pkg::OP_ROT_L;
            end
            S_TOP, S_CROP: begin
                if (r_q != r_count) begin
                    w_ctl.op = itcs_pkg::OP_ROT_L;
                end
            end
            S_REW1, S_REW2: begin
                if (r_q != r_sp) begin
                    w_ctl.op = itcs_pkg::OP_ROT_R;
                end
            end
            default: begin
            end
        endcase
    end

    for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_ring
        if (gi == 0) begin : g_head
            itcs_cell #(.IDX(gi), .CW(CW)) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_count   (r_count),
                .i_left    (w_pt[MAX_POINTS-1]),
                .i_left_gt (1'b0),
                .i_right   (w_pt[(gi + 1) % MAX_POINTS]),
                .o_pt      (w_pt[gi]),
                .o_gt      (w_gt[gi])
            );
        end else begin : g_body
            itcs_cell #(.IDX(gi), .CW(CW)) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_count   (r_count),
                .i_left    (w_pt[gi-1]),
                .i_left_gt (w_gt[gi-1]),
                .i_right   (w_pt[(gi + 1) % MAX_POINTS]),
                .o_pt      (w_pt[gi]),
                .o_gt      (w_gt[gi])
            );
        end
    end

    always_comb begin
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_mul_start = 1'b0;
        case (r_state)
            S_E_SL2: begin
                w_mul_a = NUMW'(r_sl);
                w_mul_b = MBW'(r_sl);
                w_mul_start = !r_mul_wait;
            end
            S_E_SH2: begin
                w_mul_a = NUMW'(r_sh);
                w_mul_b = MBW'(r_sh);
                w_mul_start = !r_mul_wait;
            end
            S_E_T1: begin
                w_mul_a = NUMW'(r_p1);
                w_mul_b = MBW'(w_hn_q);
                w_mul_start = !r_mul_wait;
            end
            S_E_T2: begin
                w_mul_a = NUMW'(r_p2);
                w_mul_b = MBW'(r_q);
                w_mul_start = !r_mul_wait;
            end
            S_E_DEN: begin
                w_mul_a = NUMW'(r_q);
                w_mul_b = MBW'(w_hn_q);
                w_mul_start = !r_mul_wait;
            end
            S_E_C1: begin
                w_mul_a = r_cur_num;
                w_mul_b = MBW'(r_best_den);
                w_mul_start = !r_mul_wait;
            end
            S_E_C2: begin
                w_mul_a = r_best_num;
                w_mul_b = MBW'(r_cur_den);
                w_mul_start = !r_mul_wait;
            end
            S_R_NUM: begin
                w_mul_a = NUMW'(r_sh);
                w_mul_b = MBW'(r_sp);
                w_mul_start = !r_mul_wait;
            end
            S_R_OFF: begin
                w_mul_a = NUMW'(r_ratio_offset);
                w_mul_b = MBW'(r_sp);
                w_mul_start = !r_mul_wait;
            end
            S_R_DEN: begin
                w_mul_a = NUMW'(r_rtmp);
                w_mul_b = MBW'(w_hn_sp);
                w_mul_start = !r_mul_wait;
            end
            default: begin
            end
        endcase
    end

    itcs_mul #(.WA(NUMW), .WB(MBW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    itcs_div #(.NW(RNW), .DW(RDW), .QW(QW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_DIV) && !r_div_wait),
        .i_num   (r_rnum),
        .i_den   (r_rden),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_count        <= '0;
            r_total        <= '0;
            r_out_valid    <= 1'b0;
            r_mul_wait     <= 1'b0;
            r_div_wait     <= 1'b0;
            r_crop_depth   <= itcs_pkg::CROP_DEPTH_RST;
            r_ratio_offset <= itcs_pkg::RATIO_OFFSET_RST;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    itcs_pkg::CFG_CROP_DEPTH:   r_crop_depth   <= i_cfg_wr_data;
                    itcs_pkg::CFG_RATIO_OFFSET: r_ratio_offset <= i_cfg_wr_data;
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                            r_total <= r_total + SW'(i_in.intensity);
                        end
                        if (i_in.last) begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_lo_q     <= CW'(w_lo_prod >> itcs_pkg::DIV10_SHIFT);
                    r_hi_q     <= CW'(w_hi_prod >> itcs_pkg::DIV10_SHIFT);
                    r_q        <= '0;
                    r_sl       <= '0;
                    r_have     <= 1'b0;
                    r_best_den <= DENW'(1);
                    r_best_num <= '0;
                    r_state    <= S_Q_CHECK;
                end
                S_Q_CHECK: begin
                    if (r_q == r_hi_q) begin
                        if (!r_have) begin
                            r_sp      <= r_lo_q;
                            r_best_sl <= r_sl;
                        end
                        r_state <= S_REW1;
                    end else if (r_q >= r_lo_q) begin
                        r_sh    <= r_total - r_sl;
                        r_state <= S_E_SL2;
                    end else begin
                        r_state <= S_Q_NEXT;
                    end
                end
                S_E_SL2, S_E_SH2, S_E_T1, S_E_T2, S_E_DEN, S_E_C1, S_E_C2,
                S_R_NUM, S_R_OFF, S_R_DEN: begin
                    if (!r_mul_wait) begin
                        r_mul_wait <= 1'b1;
                    end else if (w_mul_done) begin
                        r_mul_wait <= 1'b0;
                        case (r_state)
                            S_E_SL2: begin
                                r_p1    <= SQW'(w_mul_prod);
                                r_state <= S_E_SH2;
                            end
                            S_E_SH2: begin
                                r_p2    <= SQW'(w_mul_prod);
                                r_state <= S_E_T1;
                            end
                            S_E_T1: begin
                                r_cur_num <= NUMW'(w_mul_prod);
                                r_state   <= S_E_T2;
                            end
                            S_E_T2: begin
                                if (r_q == '0) begin
                                    r_cur_num <= NUMW'(r_p2);
                                end else begin
                                    r_cur_num <= r_cur_num + NUMW'(w_mul_prod);
                                end
                                r_state <= S_E_DEN;
                            end
                            S_E_DEN: begin
                                if (r_q == '0) begin
                                    r_cur_den <= DENW'(w_hn_q);
                                end else begin
                                    r_cur_den <= DENW'(w_mul_prod);
                                end
                                r_state <= S_E_C1;
                            end
                            S_E_C1: begin
                                r_c1    <= w_mul_prod;
                                r_state <= S_E_C2;
                            end
                            S_E_C2: begin
                                if (!r_have || (r_c1 > w_mul_prod)) begin
                                    r_have     <= 1'b1;
                                    r_best_num <= r_cur_num;
                                    r_best_den <= r_cur_den;
                                    r_sp       <= r_q;
                                    r_best_sl  <= r_sl;
                                end
                                r_state <= S_Q_NEXT;
                            end
                            S_R_NUM: begin
                                if (r_sp == '0) begin
                                    r_rnum <= RNW'(r_sh) << 8;
                                end else begin
                                    r_rnum <= RNW'(w_mul_prod) << 8;
                                end
                                r_state <= S_R_OFF;
                            end
                            S_R_OFF: begin
                                if (r_sp == '0) begin
                                    r_rtmp <= RDW'(r_ratio_offset);
                                end else begin
                                    r_rtmp <= RDW'(r_best_sl) + RDW'(w_mul_prod);
                                end
                                r_state <= S_R_DEN;
                            end
                            S_R_DEN: begin
                                r_rden  <= RDW'(w_mul_prod);
                                r_state <= S_DIV;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_Q_NEXT: begin
                    r_sl    <= r_sl + SW'(w_c0.intensity);
                    r_q     <= r_q + 1'b1;
                    r_state <= S_Q_CHECK;
                end
                S_REW1: begin
                    if (r_q == r_sp) begin
                        r_sh    <= r_total - r_best_sl;
                        r_state <= S_TOP_FIRST;
                    end else begin
                        r_q <= r_q - 1'b1;
                    end
                end
                S_TOP_FIRST: begin
                    r_split_int <= w_c0.intensity;
                    r_top       <= w_c0.height;
                    r_crop      <= '0;
                    r_state     <= S_TOP;
                end
                S_TOP: begin
                    if (r_q == r_count) begin
                        r_state <= S_REW2;
                    end else begin
                        if (w_c0.height > r_top) begin
                            r_top <= w_c0.height;
                        end
                        r_q <= r_q + 1'b1;
                    end
                end
                S_REW2: begin
                    if (r_q == r_sp) begin
                        r_state <= S_CROP;
                    end else begin
                        r_q <= r_q - 1'b1;
                    end
                end
                S_CROP: begin
                    if (r_q == r_count) begin
                        r_state <= S_R_NUM;
                    end else begin
                        if (w_h25 >= w_floor) begin
                            r_crop <= r_crop + 1'b1;
                        end
                        r_q <= r_q + 1'b1;
                    end
                end
                S_DIV: begin
                    if (!r_div_wait) begin
                        r_div_wait <= 1'b1;
                    end else if (w_div_done) begin
                        r_div_wait <= 1'b0;
                        r_ratio    <= w_div_quo;
                        r_state    <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid) begin
                        r_out.split_index     <= 11'(r_sp);
                        r_out.high_count      <= 11'(w_hn_sp);
                        r_out.split_intensity <= r_split_int;
                        r_out.mean_ratio      <= r_ratio;
                        r_out.top_height      <= r_top;
                        r_out.crop_count      <= 11'(r_crop);
                        r_out_valid           <= 1'b1;
                        r_count               <= '0;
                        r_total               <= '0;
                        r_state               <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

### verif/split_crop_checker.sv
`timescale 1ns / 1ps

module split_crop_checker
    import itcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wr_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_clouds_checked
);

    logic [15:0]        crop_depth;
    logic [15:0]        ratio_offset;
    logic [15:0]        inten_mem [MAX_POINTS_DEF];
    logic signed [23:0] height_mem[MAX_POINTS_DEF];
    int                 rank_order[MAX_POINTS_DEF];
    int                 stored;
    t_out               cloud_results[$];

    function automatic t_out predict_cloud();
        t_out            r;
        bit [127:0]      cur_num, best_num, lhs, rhs;
        longint unsigned n, q, lo_q, hi_q, sp, total, sl, sh, ln, hn;
        longint unsigned cur_den, best_den, num, den, ratio, crop;
        longint signed   top, floor_h, z;
        bit              have;
        n = stored;
        total = 0;
        for (int i = 0; i < n; i++) total += inten_mem[rank_order[i]];
        lo_q = n / 10;
        hi_q = n * 9 / 10;
        sp = lo_q;
        sl = 0;
        have = 0;
        best_num = 0;
        best_den = 1;
        for (q = 0; q < hi_q; q++) begin
            if (q >= lo_q) begin
                ln = q;
                hn = n - q;
                sh = total - sl;
                if (ln == 0) begin
                    cur_num = 128'(sh * sh);
                    cur_den = hn;
                end else begin
                    cur_num = 128'(sl * sl) * 128'(hn) + 128'(sh * sh) * 128'(ln);
                    cur_den = ln * hn;
                end
                lhs = cur_num * 128'(best_den);
                rhs = best_num * 128'(cur_den);
                if (!have || lhs > rhs) begin
                    have = 1;
                    best_num = cur_num;
                    best_den = cur_den;
                    sp = q;
                end
            end
            sl += inten_mem[rank_order[q]];
        end
        sl = 0;
        for (int i = 0; i < sp; i++) sl += inten_mem[rank_order[i]];
        sh = total - sl;
        ln = sp;
        hn = n - sp;
        if (ln == 0) begin
            num = sh * 256;
            den = hn * longint'(ratio_offset);
        end else begin
            num = sh * ln * 256;
            den = hn * (sl + longint'(ratio_offset) * ln);
        end
        if (den == 0) ratio = 64'hFFFFFF;
        else begin
            ratio = num / den;
            if (ratio > 64'hFFFFFF) ratio = 64'hFFFFFF;
        end
        top = height_mem[rank_order[sp]];
        for (int i = sp; i < n; i++) begin
            z = height_mem[rank_order[i]];
            if (z > top) top = z;
        end
        floor_h = top - longint'(crop_depth);
        crop = 0;
        for (int i = sp; i < n; i++) begin
            z = height_mem[rank_order[i]];
            if (z >= floor_h) crop++;
        end
        r.split_index     = 11'(sp);
        r.high_count      = 11'(hn);
        r.split_intensity = inten_mem[rank_order[sp]];
        r.mean_ratio      = 24'(ratio);
        r.top_height      = 24'(top);
        r.crop_count      = 11'(crop);
        return r;
    endfunction

    task automatic check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, act_val);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_res;
        int   pos;
        if (!i_rst_n) begin
            crop_depth   = CROP_DEPTH_RST;
            ratio_offset = RATIO_OFFSET_RST;
            stored       = 0;
            cloud_results.delete();
            o_errors         = 0;
            o_clouds_checked = 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_CROP_DEPTH) crop_depth = i_cfg_wr_data;
                else ratio_offset = i_cfg_wr_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (cloud_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %p", $time, i_out);
                    o_errors++;
                end else begin
                    exp_res = cloud_results.pop_front();
                    check_field("split_index", exp_res.split_index, i_out.split_index);
                    check_field("high_count", exp_res.high_count, i_out.high_count);
                    check_field("split_intensity", exp_res.split_intensity,
                                i_out.split_intensity);
                    check_field("mean_ratio", exp_res.mean_ratio, i_out.mean_ratio);
                    check_field("top_height", exp_res.top_height, i_out.top_height);
                    check_field("crop_count", exp_res.crop_count, i_out.crop_count);
                    o_clouds_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (stored < MAX_POINTS_DEF) begin
                    pos = stored;
                    inten_mem[stored]  = i_in.intensity;
                    height_mem[stored] = i_in.height;
                    while (pos > 0 && inten_mem[rank_order[pos - 1]] > i_in.intensity) begin
                        rank_order[pos] = rank_order[pos - 1];
                        pos--;
                    end
                    rank_order[pos] = stored;
                    stored++;
                end
                if (i_in.last) begin
                    cloud_results = {cloud_results, predict_cloud()};
                    stored = 0;
                end
            end
        end
        o_pending = cloud_results.size();
    end

endmodule

### verif/intensity_two_class_split_and_top_crop_top_tb.sv
`timescale 1ns / 1ps

module intensity_two_class_split_and_top_crop_top_tb;
    import itcs_pkg::*;

    localparam int STALL_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_in;
    logic        o_valid;
    logic        i_stall;
    t_out        o_out;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [15:0] i_cfg_wr_data;

    int errors, pending, clouds_checked;
    int send_idle_pct, recv_stall_pct;
    int points_sent, quiet_cycles;

    intensity_two_class_split_and_top_crop_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in         (i_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out        (o_out),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    split_crop_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in            (i_in),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out           (o_out),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_clouds_checked(clouds_checked)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_point(logic [15:0] inten, logic signed [23:0] height, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_in.intensity <= inten;
        i_in.height    <= height;
        i_in.last      <= last;
        do @(posedge i_clk); while (o_stall);
        points_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= index;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_cloud(int size);
        int                 mode;
        logic signed [23:0] base;
        logic [15:0]        inten;
        logic signed [23:0] height;
        mode = $urandom_range(3);
        base = 24'($urandom);
        for (int k = 0; k < size; k++) begin
            case (mode)
                0: inten = 16'($urandom);
                1: inten = 16'($urandom_range(3)) << 14;
                2: inten = ($urandom_range(1)) ? 16'($urandom_range(16'hFFFF, 16'hC000))
                                               : 16'($urandom_range(16'h1000));
                default: inten = 16'($urandom_range(7));
            endcase
            if ($urandom_range(1)) height = 24'($urandom);
            else height = base + 24'($urandom_range(600)) - 24'd300;
            send_point(inten, height, k == size - 1);
        end
    endtask

    task automatic random_clouds(int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(4) == 0) begin
                send_cloud($urandom_range(60, 25));
                sent = sent + 42;
            end else begin
                send_cloud($urandom_range(24, 1));
                sent = sent + 12;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in          = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_CROP_DEPTH;
        i_cfg_wr_data = '0;
        i_stall       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        points_sent    = 0;
        quiet_cycles   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults first, then both extremes low
        send_point(16'hFFFF, -24'sd8388608, 1'b1);
        send_point(16'h0000, 24'sd8388607, 1'b1);
        drain();
        write_reg(CFG_CROP_DEPTH, 16'd0);
        write_reg(CFG_RATIO_OFFSET, 16'd0);
        for (int k = 0; k < 3; k++) send_point(16'h0000, 24'(k * 5), k == 2);
        send_point(16'h0000, 24'sd100, 1'b1);
        for (int k = 0; k < 10; k++)
            send_point((k % 3 == 0) ? 16'h0100 : 16'hFF00, 24'(k - 5), k == 9);
        for (int k = 0; k < 4; k++) send_point(16'h8000, 24'sd7, k == 3);
        random_clouds(250);
        drain();

        send_idle_pct = 83;
        write_reg(CFG_CROP_DEPTH, 16'hFFFF);
        write_reg(CFG_RATIO_OFFSET, 16'hFFFF);
        random_clouds(250);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 83;
        write_reg(CFG_CROP_DEPTH, CROP_DEPTH_RST);
        write_reg(CFG_RATIO_OFFSET, RATIO_OFFSET_RST);
        random_clouds(250);
        drain();

        send_idle_pct  = 33;
        recv_stall_pct = 33;
        write_reg(CFG_CROP_DEPTH, 16'($urandom_range(2000)));
        write_reg(CFG_RATIO_OFFSET, 16'($urandom));
        random_clouds(280);
        drain();

        $display("Covered %0d point beats in %0d clouds, from single points to clouds of sixty,",
                 points_sent, clouds_checked);
        $display("under free-running, sender-idle, receiver-stall and mixed handshake phases.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
design/itcs_pkg.sv
design/itcs_cell.sv
design/itcs_mul.sv
design/itcs_div.sv
design/intensity_two_class_split_and_top_crop_top.sv
verif/split_crop_checker.sv
verif/intensity_two_class_split_and_top_crop_top_tb.sv
